// ===== hw/rtl/ppl_pkg.sv =====
package ppl_pkg;

	localparam int REGION_COUNT = 10;
	localparam int COEF_ROWS    = 10;
	localparam int REGION_SPAN  = ((100 / REGION_COUNT) > 0) ? (100 / REGION_COUNT) : 1;
	localparam int LAST_REGION  = ((REGION_COUNT < COEF_ROWS) ? REGION_COUNT : COEF_ROWS) - 1;
	localparam int REGION_W     = $clog2(COEF_ROWS);

	localparam int QUO_BITS  = 7;
	localparam int STEP_W    = $clog2(QUO_BITS);
	localparam int DEN_SHIFT = 8;
	localparam int OFF_SHIFT = 8;
	localparam int P_SHIFT   = 8;
	localparam int Q_SHIFT   = 12;

	localparam logic [6:0]  POWER_MAX    = 7'd100;
	localparam logic [11:0] PRESSURE_MAX = 12'd4095;
	localparam logic [11:0] TARGET_RESET = 12'd2432;

	localparam logic [1:0] CMD_SET_POWER = 2'd0;
	localparam logic [1:0] CMD_LOCK      = 2'd1;
	localparam logic [1:0] CMD_UNLOCK    = 2'd2;

	localparam int         CFG_INDEX_W         = 1;
	localparam int         CFG_DATA_W          = 12;
	localparam logic [0:0] CFG_TARGET_PRESSURE = 1'd0;
	localparam logic [0:0] CFG_FLOW_METER      = 1'd1;

	localparam int OFF_Q12 [0:COEF_ROWS-1] = '{
		0, 10824, 16562, 10647, 9487, 7626, 23061, 26674, 9850, 14452};
	localparam int PGAIN_Q12 [0:COEF_ROWS-1] = '{
		1769, 281, 262, 584, 628, 666, 391, 347, 575, 515};
	localparam int FGAIN_Q12 [0:COEF_ROWS-1] = '{
		-2653, -4113, -5289, -6150, -6427, -6913, -6841, -6722, -6957, -6897};

	localparam logic [6:0] DUTY_TABLE [0:100] = '{
		7'd0,   7'd60,  7'd61,  7'd61,  7'd62,  7'd63,  7'd63,  7'd64,  7'd65,  7'd65,
		7'd66,  7'd67,  7'd67,  7'd68,  7'd69,  7'd69,  7'd70,  7'd71,  7'd72,  7'd72,
		7'd73,  7'd74,  7'd74,  7'd75,  7'd76,  7'd76,  7'd77,  7'd78,  7'd78,  7'd79,
		7'd80,  7'd80,  7'd81,  7'd82,  7'd82,  7'd83,  7'd84,  7'd84,  7'd85,  7'd86,
		7'd86,  7'd87,  7'd88,  7'd88,  7'd89,  7'd90,  7'd90,  7'd91,  7'd92,  7'd92,
		7'd93,  7'd94,  7'd95,  7'd95,  7'd96,  7'd97,  7'd97,  7'd98,  7'd99,  7'd99,
		7'd100, 7'd101, 7'd101, 7'd102, 7'd103, 7'd103, 7'd104, 7'd105, 7'd105, 7'd106,
		7'd107, 7'd107, 7'd108, 7'd109, 7'd109, 7'd110, 7'd111, 7'd111, 7'd112, 7'd113,
		7'd113, 7'd114, 7'd115, 7'd115, 7'd116, 7'd117, 7'd118, 7'd118, 7'd119, 7'd120,
		7'd120, 7'd121, 7'd122, 7'd122, 7'd123, 7'd124, 7'd124, 7'd125, 7'd126, 7'd126,
		7'd127};

	typedef struct packed {
		logic [1:0]  command;
		logic [6:0]  requested_power;
		logic [11:0] flow_rate;
	} ppl_in_t;

	typedef struct packed {
		logic [6:0]  applied_power;
		logic [6:0]  duty_level;
		logic [11:0] pressure_estimate;
		logic [6:0]  power_limit;
		logic        is_locked;
	} ppl_out_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_LIM_MUL,
		S_LIM_CMP,
		S_LIM_NUM,
		S_DIV_CHK,
		S_DIV,
		S_DIV_END,
		S_APPLY,
		S_EST_IDX,
		S_EST_MUL_F,
		S_EST_MUL_P,
		S_EST_SUM,
		S_DONE
	} ppl_state_t;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_LOAD,
		OP_LIM_MUL,
		OP_NEXT_REGION,
		OP_LIM_NUM,
		OP_LIM_ZERO,
		OP_LIM_FULL,
		OP_DIV_INIT,
		OP_DIV_STEP,
		OP_DIV_END,
		OP_APPLY,
		OP_EST_IDX,
		OP_EST_ZERO,
		OP_EST_MUL_F,
		OP_EST_MUL_P,
		OP_EST_SUM,
		OP_OUT_LOAD
	} ppl_op_t;

	typedef struct packed {
		logic meter;
		logic reach_gt;
		logic region_last;
		logic num_nonpos;
		logic div_over;
		logic step_last;
		logic out_free;
	} ppl_status_t;

	function automatic logic signed [31:0] reach_base(input logic [REGION_W-1:0] idx);
		logic signed [31:0] res;
		res = '0;
		for (int i = 0; i < COEF_ROWS; i++) begin
			if (32'(idx) == i) begin
				res = 32'(OFF_Q12[i] * 256 + PGAIN_Q12[i] * REGION_SPAN * (i + 1) * 256);
			end
		end
		return res;
	endfunction

	function automatic logic [REGION_W-1:0] region_of(input logic [6:0] power);
		logic [REGION_W-1:0] r;
		r = '0;
		for (int i = 1; i <= LAST_REGION; i++) begin
			if (32'(power) >= i * REGION_SPAN) begin
				r = REGION_W'(i);
			end
		end
		return r;
	endfunction

endpackage

// ===== hw/rtl/ppl_ctrl.sv =====
module ppl_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  ppl_pkg::ppl_status_t st,
	output ppl_pkg::ppl_op_t     op
);

	ppl_pkg::ppl_state_t state_q;
	ppl_pkg::ppl_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ppl_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		op       = ppl_pkg::OP_NONE;
		in_ready = 1'b0;
		case (state_q)
			ppl_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					op      = ppl_pkg::OP_LOAD;
					state_d = ppl_pkg::S_LIM_MUL;
				end
			end
			ppl_pkg::S_LIM_MUL: begin
				if (!st.meter) begin
					op      = ppl_pkg::OP_LIM_ZERO;
					state_d = ppl_pkg::S_APPLY;
				end else begin
					op      = ppl_pkg::OP_LIM_MUL;
					state_d = ppl_pkg::S_LIM_CMP;
				end
			end
			ppl_pkg::S_LIM_CMP: begin
				if (st.reach_gt) begin
					state_d = ppl_pkg::S_LIM_NUM;
				end else if (st.region_last) begin
					op      = ppl_pkg::OP_LIM_FULL;
					state_d = ppl_pkg::S_APPLY;
				end else begin
					op      = ppl_pkg::OP_NEXT_REGION;
					state_d = ppl_pkg::S_LIM_MUL;
				end
			end
			ppl_pkg::S_LIM_NUM: begin
				op      = ppl_pkg::OP_LIM_NUM;
				state_d = ppl_pkg::S_DIV_CHK;
			end
			ppl_pkg::S_DIV_CHK: begin
				if (st.num_nonpos) begin
					op      = ppl_pkg::OP_LIM_ZERO;
					state_d = ppl_pkg::S_APPLY;
				end else if (st.div_over) begin
					op      = ppl_pkg::OP_LIM_FULL;
					state_d = ppl_pkg::S_APPLY;
				end else begin
					op      = ppl_pkg::OP_DIV_INIT;
					state_d = ppl_pkg::S_DIV;
				end
			end
			ppl_pkg::S_DIV: begin
				op = ppl_pkg::OP_DIV_STEP;
				if (st.step_last) begin
					state_d = ppl_pkg::S_DIV_END;
				end
			end
			ppl_pkg::S_DIV_END: begin
				op      = ppl_pkg::OP_DIV_END;
				state_d = ppl_pkg::S_APPLY;
			end
			ppl_pkg::S_APPLY: begin
				op      = ppl_pkg::OP_APPLY;
				state_d = ppl_pkg::S_EST_IDX;
			end
			ppl_pkg::S_EST_IDX: begin
				if (!st.meter) begin
					op      = ppl_pkg::OP_EST_ZERO;
					state_d = ppl_pkg::S_DONE;
				end else begin
					op      = ppl_pkg::OP_EST_IDX;
					state_d = ppl_pkg::S_EST_MUL_F;
				end
			end
			ppl_pkg::S_EST_MUL_F: begin
				op      = ppl_pkg::OP_EST_MUL_F;
				state_d = ppl_pkg::S_EST_MUL_P;
			end
			ppl_pkg::S_EST_MUL_P: begin
				op      = ppl_pkg::OP_EST_MUL_P;
				state_d = ppl_pkg::S_EST_SUM;
			end
			ppl_pkg::S_EST_SUM: begin
				op      = ppl_pkg::OP_EST_SUM;
				state_d = ppl_pkg::S_DONE;
			end
			ppl_pkg::S_DONE: begin
				if (st.out_free) begin
					op      = ppl_pkg::OP_OUT_LOAD;
					state_d = ppl_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = ppl_pkg::S_IDLE;
			end
		endcase
	end

endmodule

// ===== hw/rtl/ppl_dp.sv =====
module ppl_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  ppl_pkg::ppl_in_t                  in_data,
	output logic                              out_valid,
	input  logic                              out_ready,
	output ppl_pkg::ppl_out_t                 out_data,
	input  logic                              cfg_we,
	input  logic [ppl_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [ppl_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  ppl_pkg::ppl_op_t                  op,
	output ppl_pkg::ppl_status_t              st
);

	logic [11:0]                     target_q;
	logic                            meter_q;
	logic                            lock_q;
	logic [6:0]                      power_q;
	logic [1:0]                      cmd_q;
	logic [6:0]                      req_q;
	logic [11:0]                     flow_q;
	logic [ppl_pkg::REGION_W-1:0]    ridx_q;
	logic signed [31:0]              prod_q;
	logic signed [31:0]              rem_q;
	logic signed [31:0]              acc_q;
	logic [ppl_pkg::QUO_BITS-1:0]    quo_q;
	logic [ppl_pkg::STEP_W-1:0]      step_q;
	logic [6:0]                      limit_q;
	logic                            out_valid_q;
	ppl_pkg::ppl_out_t               out_q;

	logic signed [14:0]              mul_a;
	logic signed [12:0]              mul_b;
	logic signed [27:0]              mul_p;
	logic signed [31:0]              tgt_ext;
	logic signed [31:0]              off_ext;
	logic signed [31:0]              den_ext;
	logic signed [31:0]              trial;
	logic signed [31:0]              acc_shr;
	logic [11:0]                     pressure;

	always_comb begin
		if (op == ppl_pkg::OP_EST_MUL_P) begin
			mul_a = 15'(ppl_pkg::PGAIN_Q12[ridx_q]);
			mul_b = $signed({6'd0, power_q});
		end else begin
			mul_a = 15'(ppl_pkg::FGAIN_Q12[ridx_q]);
			mul_b = $signed({1'b0, flow_q});
		end
	end

	assign mul_p   = mul_a * mul_b;
	assign tgt_ext = $signed({8'd0, target_q, 12'd0});
	assign off_ext = 32'(ppl_pkg::OFF_Q12[ridx_q] * 256);
	assign den_ext = 32'(ppl_pkg::PGAIN_Q12[ridx_q] * 256);
	assign trial   = den_ext <<< step_q;
	assign acc_shr = acc_q >>> ppl_pkg::Q_SHIFT;

	always_comb begin
		if (acc_q <= 32'sd0) begin
			pressure = '0;
		end else if (acc_shr > $signed({20'd0, ppl_pkg::PRESSURE_MAX})) begin
			pressure = ppl_pkg::PRESSURE_MAX;
		end else begin
			pressure = acc_shr[11:0];
		end
	end

	always_comb begin
		st.meter       = meter_q;
		st.reach_gt    = (ppl_pkg::reach_base(ridx_q) + prod_q) > tgt_ext;
		st.region_last = (32'(ridx_q) == ppl_pkg::LAST_REGION);
		st.num_nonpos  = rem_q <= 32'sd0;
		st.div_over    = rem_q >= (den_ext <<< ppl_pkg::QUO_BITS);
		st.step_last   = step_q == '0;
		st.out_free    = !out_valid_q || out_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= ppl_pkg::TARGET_RESET;
			meter_q  <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				ppl_pkg::CFG_TARGET_PRESSURE: target_q <= cfg_data[11:0];
				ppl_pkg::CFG_FLOW_METER:      meter_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lock_q      <= 1'b1;
			power_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (op == ppl_pkg::OP_APPLY) begin
				case (cmd_q)
					ppl_pkg::CMD_SET_POWER: begin
						if (!lock_q) begin
							power_q <= (req_q > limit_q) ? limit_q : req_q;
						end
					end
					ppl_pkg::CMD_LOCK: begin
						lock_q  <= 1'b1;
						power_q <= '0;
					end
					ppl_pkg::CMD_UNLOCK: begin
						lock_q <= 1'b0;
					end
					default: ;
				endcase
			end
			if (op == ppl_pkg::OP_OUT_LOAD) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (op)
			ppl_pkg::OP_LOAD: begin
				cmd_q  <= in_data.command;
				req_q  <= in_data.requested_power;
				flow_q <= in_data.flow_rate;
				ridx_q <= '0;
			end
			ppl_pkg::OP_LIM_MUL: begin
				prod_q <= 32'(mul_p);
			end
			ppl_pkg::OP_NEXT_REGION: begin
				ridx_q <= ridx_q + 1'b1;
			end
			ppl_pkg::OP_LIM_NUM: begin
				rem_q <= tgt_ext - prod_q - off_ext;
			end
			ppl_pkg::OP_LIM_ZERO: begin
				limit_q <= '0;
			end
			ppl_pkg::OP_LIM_FULL: begin
				limit_q <= ppl_pkg::POWER_MAX;
			end
			ppl_pkg::OP_DIV_INIT: begin
				quo_q  <= '0;
				step_q <= ppl_pkg::STEP_W'(ppl_pkg::QUO_BITS - 1);
			end
			ppl_pkg::OP_DIV_STEP: begin
				if (rem_q >= trial) begin
					rem_q         <= rem_q - trial;
					quo_q[step_q] <= 1'b1;
				end
				step_q <= step_q - 1'b1;
			end
			ppl_pkg::OP_DIV_END: begin
				limit_q <= (quo_q > ppl_pkg::POWER_MAX) ? ppl_pkg::POWER_MAX : quo_q;
			end
			ppl_pkg::OP_EST_IDX: begin
				ridx_q <= ppl_pkg::region_of(power_q);
			end
			ppl_pkg::OP_EST_ZERO: begin
				acc_q <= '0;
			end
			ppl_pkg::OP_EST_MUL_F: begin
				prod_q <= 32'(mul_p);
			end
			ppl_pkg::OP_EST_MUL_P: begin
				acc_q  <= off_ext + prod_q;
				prod_q <= 32'(mul_p);
			end
			ppl_pkg::OP_EST_SUM: begin
				acc_q <= acc_q + (prod_q <<< ppl_pkg::P_SHIFT);
			end
			ppl_pkg::OP_OUT_LOAD: begin
				out_q.applied_power     <= power_q;
				out_q.duty_level        <= ppl_pkg::DUTY_TABLE[power_q];
				out_q.pressure_estimate <= pressure;
				out_q.power_limit       <= limit_q;
				out_q.is_locked         <= lock_q;
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// ===== hw/rtl/pump_pressure_limited_power.sv =====
// The region search multiplies and compares region by region on one shared multiplier, and the
// power limit then takes a seven-step restoring divider; the estimate then indexes, multiplies and sums.
// One transaction at a time: the next is taken in the cycle after the result loads.
// Reset (arst_n low): locked, power 0, target 9.5 bar, no flow meter, no result pending.
module pump_pressure_limited_power (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  ppl_pkg::ppl_in_t                in_data,
	output logic                            out_valid,
	input  logic                            out_ready,
	output ppl_pkg::ppl_out_t               out_data,
	input  logic                            cfg_we,
	input  logic [ppl_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [ppl_pkg::CFG_DATA_W-1:0]  cfg_data
);

	ppl_pkg::ppl_op_t     op;
	ppl_pkg::ppl_status_t st;

	ppl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.st       (st),
		.op       (op)
	);

	ppl_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.op        (op),
		.st        (st)
	);

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps

module tb;
	import ppl_pkg::*;

	localparam logic [1:0] CMD_SPARE = 2'd3;
	localparam int CYCLE_LIMIT = 500000;
	localparam int PRINT_CAP = 40;

	logic clk;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	ppl_in_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	ppl_out_t out_data;
	logic cfg_we = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	ppl_in_t commands_pending[$];
	ppl_out_t reports_due[$];

	logic [11:0] target_setting = TARGET_RESET;
	logic meter_fitted = 1'b0;
	logic locked_state = 1'b1;
	logic [6:0] power_state = 7'd0;

	bit calm = 1'b0;
	int send_gap = 0;
	int recv_stall = 0;
	int mismatch_count = 0;
	int cycle_count = 0;

	pump_pressure_limited_power DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic logic [6:0] power_ceiling(input logic [11:0] flow);
		longint tgt, reach, num, den, q, f;
		tgt = longint'(target_setting) * 4096;
		f = longint'(flow);
		if (!meter_fitted) return 7'd0;
		for (int r = 0; r <= LAST_REGION; r++) begin
			reach = longint'(OFF_Q12[r]) * 256
				+ longint'(PGAIN_Q12[r]) * REGION_SPAN * (r + 1) * 256
				+ longint'(FGAIN_Q12[r]) * f;
			if (reach > tgt) begin
				num = tgt - longint'(FGAIN_Q12[r]) * f - longint'(OFF_Q12[r]) * 256;
				den = longint'(PGAIN_Q12[r]) * 256;
				if (num <= 0) return 7'd0;
				q = num / den;
				return (q > 100) ? POWER_MAX : 7'(q);
			end
		end
		return POWER_MAX;
	endfunction

	function automatic logic [11:0] pressure_guess(input logic [6:0] power, input logic [11:0] flow);
		int r;
		longint p, f;
		if (!meter_fitted) return 12'd0;
		f = longint'(flow);
		r = int'(power) / REGION_SPAN;
		if (r > LAST_REGION) r = LAST_REGION;
		p = longint'(OFF_Q12[r]) * 256
			+ longint'(PGAIN_Q12[r]) * longint'(power) * 256
			+ longint'(FGAIN_Q12[r]) * f;
		if (p <= 0) return 12'd0;
		p = p / 4096;
		return (p > 4095) ? PRESSURE_MAX : 12'(p);
	endfunction

	task automatic apply_command(input ppl_in_t c);
		logic [6:0] ceiling;
		ppl_out_t r;
		ceiling = power_ceiling(c.flow_rate);
		case (c.command)
			CMD_SET_POWER: begin
				if (!locked_state)
					power_state = (c.requested_power > ceiling) ? ceiling : c.requested_power;
			end
			CMD_LOCK: begin
				locked_state = 1'b1;
				power_state = 7'd0;
			end
			CMD_UNLOCK: begin
				locked_state = 1'b0;
			end
			default: begin
			end
		endcase
		r.applied_power = power_state;
		r.duty_level = DUTY_TABLE[power_state];
		r.pressure_estimate = pressure_guess(power_state, c.flow_rate);
		r.power_limit = ceiling;
		r.is_locked = locked_state;
		reports_due.push_back(r);
	endtask

	task automatic flag_mismatch(input string msg);
		if (mismatch_count < PRINT_CAP)
			$display("MISMATCH at %0t: %s", $time, msg);
		mismatch_count++;
	endtask

	task automatic compare_field(input string name, input logic [11:0] got, input logic [11:0] want);
		if (got !== want)
			flag_mismatch($sformatf("%s got %0d want %0d", name, got, want));
	endtask

	task automatic check_report(input ppl_out_t got);
		ppl_out_t want;
		if (reports_due.size() == 0) begin
			flag_mismatch($sformatf("unexpected transaction %h", got));
			return;
		end
		want = reports_due.pop_front();
		compare_field("applied_power", 12'(got.applied_power), 12'(want.applied_power));
		compare_field("duty_level", 12'(got.duty_level), 12'(want.duty_level));
		compare_field("pressure_estimate", got.pressure_estimate, want.pressure_estimate);
		compare_field("power_limit", 12'(got.power_limit), 12'(want.power_limit));
		compare_field("is_locked", 12'(got.is_locked), 12'(want.is_locked));
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready)
				apply_command(in_data);
			if (!in_valid || in_ready) begin
				if (send_gap > 0) begin
					send_gap--;
					in_valid <= 1'b0;
				end else if (commands_pending.size() > 0) begin
					in_data <= commands_pending.pop_front();
					in_valid <= 1'b1;
					if (!calm && $urandom_range(0, 5) == 0)
						send_gap = $urandom_range(1, 13);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready)
				check_report(out_data);
			if (recv_stall > 0) begin
				recv_stall--;
				out_ready <= 1'b0;
			end else if (!calm && $urandom_range(0, 6) == 0) begin
				recv_stall = $urandom_range(0, 12);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	function automatic ppl_in_t pump_cmd(input logic [1:0] cmd, input logic [6:0] req,
			input logic [11:0] flow);
		ppl_in_t c;
		c.command = cmd;
		c.requested_power = req;
		c.flow_rate = flow;
		return c;
	endfunction

	function automatic ppl_in_t random_command();
		int sel;
		logic [1:0] cmd;
		logic [6:0] req;
		logic [11:0] flow;
		sel = $urandom_range(0, 99);
		if (sel < 65) cmd = CMD_SET_POWER;
		else if (sel < 85) cmd = CMD_UNLOCK;
		else if (sel < 95) cmd = CMD_LOCK;
		else cmd = CMD_SPARE;
		req = ($urandom_range(0, 9) == 0) ? 7'($urandom_range(101, 127)) : 7'($urandom_range(0, 100));
		case ($urandom_range(0, 3))
			0, 1: flow = 12'($urandom_range(0, 1023));
			2: flow = 12'($urandom_range(0, 4095));
			default: flow = 12'($urandom_range(1024, 4095));
		endcase
		return pump_cmd(cmd, req, flow);
	endfunction

	task automatic queue_random(input int count);
		repeat (count) commands_pending.push_back(random_command());
	endtask

	task automatic wait_idle();
		while (commands_pending.size() > 0 || in_valid || reports_due.size() > 0)
			@(negedge clk);
	endtask

	task automatic write_setting(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		wait_idle();
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_TARGET_PRESSURE)
			target_setting = val;
		else
			meter_fitted = val[0];
		@(negedge clk);
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// no flow meter: limit and pressure stay zero
		commands_pending.push_back(pump_cmd(CMD_SET_POWER, 7'd50, 12'd100));
		commands_pending.push_back(pump_cmd(CMD_UNLOCK, 7'd0, 12'd0));
		commands_pending.push_back(pump_cmd(CMD_SET_POWER, 7'd100, 12'd0));
		commands_pending.push_back(pump_cmd(CMD_SET_POWER, 7'd127, 12'd4095));
		commands_pending.push_back(pump_cmd(CMD_SPARE, 7'd5, 12'd7));
		commands_pending.push_back(pump_cmd(CMD_LOCK, 7'd0, 12'd0));
		commands_pending.push_back(pump_cmd(CMD_LOCK, 7'd127, 12'd4095));
		queue_random(40);

		write_setting(CFG_FLOW_METER, 12'd1);
		write_setting(CFG_TARGET_PRESSURE, TARGET_RESET);
		commands_pending.push_back(pump_cmd(CMD_UNLOCK, 7'd0, 12'd0));
		commands_pending.push_back(pump_cmd(CMD_SET_POWER, 7'd100, 12'd0));
		commands_pending.push_back(pump_cmd(CMD_SET_POWER, 7'd0, 12'd0));
		commands_pending.push_back(pump_cmd(CMD_SET_POWER, 7'd127, 12'd4095));
		commands_pending.push_back(pump_cmd(CMD_SET_POWER, 7'd100, 12'd4095));
		commands_pending.push_back(pump_cmd(CMD_SET_POWER, 7'd100, 12'd2048));
		commands_pending.push_back(pump_cmd(CMD_SET_POWER, 7'd60, 12'd512));
		commands_pending.push_back(pump_cmd(CMD_LOCK, 7'd100, 12'd300));
		commands_pending.push_back(pump_cmd(CMD_LOCK, 7'd0, 12'd300));
		commands_pending.push_back(pump_cmd(CMD_SET_POWER, 7'd80, 12'd300));
		commands_pending.push_back(pump_cmd(CMD_SPARE, 7'd127, 12'd4095));
		commands_pending.push_back(pump_cmd(CMD_UNLOCK, 7'd42, 12'd2730));
		commands_pending.push_back(pump_cmd(CMD_SET_POWER, 7'd85, 12'd1365));
		commands_pending.push_back(pump_cmd(CMD_SET_POWER, 7'd42, 12'd2730));
		queue_random(120);

		// high ceiling: at the nonzero flows queued here no region reaches it, full power allowed
		write_setting(CFG_TARGET_PRESSURE, 12'd4095);
		commands_pending.push_back(pump_cmd(CMD_UNLOCK, 7'd0, 12'd200));
		commands_pending.push_back(pump_cmd(CMD_SET_POWER, 7'd100, 12'd200));
		commands_pending.push_back(pump_cmd(CMD_SET_POWER, 7'd127, 12'd0));
		commands_pending.push_back(pump_cmd(CMD_SET_POWER, 7'd100, 12'd4095));
		queue_random(120);

		write_setting(CFG_TARGET_PRESSURE, 12'd0);
		queue_random(100);

		write_setting(CFG_FLOW_METER, 12'd0);
		queue_random(60);

		write_setting(CFG_FLOW_METER, 12'd1);
		repeat (3) begin
			write_setting(CFG_TARGET_PRESSURE, 12'($urandom_range(0, 4095)));
			queue_random(80);
		end

		write_setting(CFG_TARGET_PRESSURE, 12'($urandom_range(1500, 3500)));
		calm = 1'b1;
		queue_random(120);

		wait_idle();
		repeat (40) @(posedge clk);
		if (mismatch_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
